// ===== design/hsbe_pkg.sv =====
`default_nettype none
package hsbe_pkg;

	// Request codes; the unused code acts as a search.
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_SEARCH = 2'd2,
		KIND_SPARE  = 2'd3
	} kind_t;

	localparam int KEY_W   = 63;
	localparam int VALUE_W = 64;
	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	// Request payload.
	typedef struct packed {
		logic [1:0]         kind;
		logic [KEY_W-1:0]   item_key;
		logic [VALUE_W-1:0] item_value;
	} req_t;

	// Result payload.
	typedef struct packed {
		logic success;
		logic bucket_full;
	} rsp_t;

endpackage
`default_nettype wire

// ===== design/hsbe_req_if.sv =====
`default_nettype none
interface hsbe_req_if;
	logic               valid;
	logic               ready;
	hsbe_pkg::req_t     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/hsbe_rsp_if.sv =====
`default_nettype none
interface hsbe_rsp_if;
	logic           valid;
	logic           ready;
	hsbe_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/hsbe_cfg_if.sv =====
`default_nettype none
interface hsbe_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hsbe_pkg::COUNT_W-1:0]   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/hsbe_ram.sv =====
`default_nettype none
module hsbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/hsbe_front.sv =====
`default_nettype none
// Front end: accepts requests and reduces the key to its bucket with a
// restoring divider, one quotient bit per cycle.
module hsbe_front #(
	parameter int MAX_BUCKETS = 1024,
	localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	hsbe_req_if.sink                           req,
	input  wire logic [hsbe_pkg::COUNT_W-1:0]  bucket_count,
	output logic                               job_valid,
	input  wire logic                          job_ready,
	output logic [1:0]                         job_kind,
	output logic [hsbe_pkg::KEY_W-1:0]         job_key,
	output logic [BKT_W-1:0]                   job_bucket
);

	localparam int KEY_W = hsbe_pkg::KEY_W;
	localparam int CNT_W = $clog2(KEY_W + 1);
	localparam int DIV_W = (hsbe_pkg::COUNT_W > BKT_W + 1) ? hsbe_pkg::COUNT_W : BKT_W + 1;
	localparam int REM_W = DIV_W + 1;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_DONE = 3'b100
	} fstate_t;

	fstate_t            state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [KEY_W-1:0]   shift_q;
	logic [REM_W-1:0]   rem_q;
	logic [DIV_W-1:0]   div_q;
	logic [DIV_W-1:0]   eff_count;
	logic [REM_W-1:0]   rem_sh;
	logic [REM_W-1:0]   rem_sub;

	// Clamp the divisor into one to MAX_BUCKETS.
	always_comb begin
		eff_count = DIV_W'(bucket_count);
		if (bucket_count == '0) begin
			eff_count = DIV_W'(1);
		end else if (DIV_W'(bucket_count) > DIV_W'(MAX_BUCKETS)) begin
			eff_count = DIV_W'(MAX_BUCKETS);
		end
	end

	// One restoring step of the remainder.
	always_comb begin
		rem_sh  = {rem_q[REM_W-2:0], shift_q[KEY_W-1]};
		rem_sub = rem_sh - {1'b0, div_q};
	end

	assign req.ready  = (state_q == F_IDLE);
	assign job_valid  = (state_q == F_DONE);
	assign job_bucket = rem_q[BKT_W-1:0];

	// Divider sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (req.valid) begin
						state_q <= F_DIV;
						cnt_q   <= CNT_W'(KEY_W);
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= F_DONE;
					end
				end
				F_DONE: begin
					if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && req.valid) begin
			job_kind <= req.payload.kind;
			job_key  <= req.payload.item_key;
			shift_q  <= req.payload.item_key;
			rem_q    <= '0;
			div_q    <= eff_count;
		end else if (state_q == F_DIV) begin
			shift_q <= {shift_q[KEY_W-2:0], 1'b0};
			rem_q   <= rem_sub[REM_W-1] ? rem_sh : rem_sub;
		end
	end

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> (rem_q < {1'b0, div_q})) else $error("remainder not reduced");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV && cnt_q == CNT_W'(1)) |=> job_valid) else $error("divider length");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV) |-> (div_q != '0)) else $error("zero divisor");
`endif

endmodule
`default_nettype wire

// ===== design/hsbe_queue.sv =====
`default_nettype none
// Two-entry queue between front and back end.
module hsbe_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);

	logic [WIDTH-1:0] data_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = data_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wp_q] <= in_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1)) else $error("pop lost");
	a_push_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("push lost");
`endif

endmodule
`default_nettype wire

// ===== design/hsbe_back.sv =====
`default_nettype none
// Back end: clears the slot valid bits once after reset, then scans the
// bucket's slots one a cycle, writes back and registers the result.
module hsbe_back #(
	parameter int MAX_BUCKETS = 1024,
	parameter int SLOTS_PER_BUCKET = 8,
	localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      job_valid,
	output logic                           job_ready,
	input  wire logic [1:0]                job_kind,
	input  wire logic [hsbe_pkg::KEY_W-1:0] job_key,
	input  wire logic [BKT_W-1:0]          job_bucket,
	input  wire logic [hsbe_pkg::VALUE_W-1:0] job_value,
	hsbe_rsp_if.source                     rsp
);

	localparam int KEY_W   = hsbe_pkg::KEY_W;
	localparam int SLOT_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int TOTAL   = MAX_BUCKETS * SLOTS_PER_BUCKET;
	localparam int ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int SCNT_W  = $clog2(SLOTS_PER_BUCKET + 1);

	typedef enum logic [5:0] {
		B_CLEAR = 6'b000001,
		B_IDLE  = 6'b000010,
		B_READ  = 6'b000100,
		B_CHECK = 6'b001000,
		B_WRITE = 6'b010000,
		B_RESP  = 6'b100000
	} bstate_t;

	bstate_t            state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [SCNT_W-1:0]  rd_q;
	logic [SCNT_W-1:0]  chk_q;
	logic [1:0]         kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [hsbe_pkg::VALUE_W-1:0] value_q;
	logic [ADDR_W-1:0]  base_q;
	logic               hit_q;
	logic [SLOT_W-1:0]  hit_slot_q;
	logic               free_q;
	logic [SLOT_W-1:0]  free_slot_q;
	logic               valid_rd;
	logic [KEY_W-1:0]   key_rd;
	logic [ADDR_W-1:0]  raddr;
	logic               we;
	logic               val_we;
	logic [ADDR_W-1:0]  waddr;
	logic               vld_we;
	logic               vld_wdata;
	logic [ADDR_W-1:0]  vld_waddr;
	logic               is_insert;
	logic               is_delete;
	logic               rsp_valid_q;
	hsbe_pkg::rsp_t     rsp_q;

	assign is_insert = (hsbe_pkg::kind_t'(kind_q) == hsbe_pkg::KIND_INSERT);
	assign is_delete = (hsbe_pkg::kind_t'(kind_q) == hsbe_pkg::KIND_DELETE);
	assign raddr     = base_q + ADDR_W'(rd_q[SLOT_W-1:0]);
	assign job_ready = (state_q == B_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Write-back address and enables; the clearing pass owns the valid RAM.
	always_comb begin
		waddr  = base_q + ADDR_W'(free_slot_q);
		we     = (state_q == B_WRITE) && is_insert && !hit_q && free_q;
		val_we = we;
		if (is_delete) waddr = base_q + ADDR_W'(hit_slot_q);
		vld_we    = we || ((state_q == B_WRITE) && is_delete && hit_q);
		vld_wdata = we;
		vld_waddr = waddr;
		if (state_q == B_CLEAR) begin
			vld_we    = 1'b1;
			vld_wdata = 1'b0;
			vld_waddr = clr_q;
		end
	end

	hsbe_ram #(.WIDTH(KEY_W), .DEPTH(TOTAL)) u_keys (
		.clk(clk), .we(we), .waddr(waddr), .wdata(key_q), .raddr(raddr), .rdata(key_rd)
	);

	hsbe_ram #(.WIDTH(hsbe_pkg::VALUE_W), .DEPTH(TOTAL)) u_values (
		.clk(clk), .we(val_we), .waddr(waddr), .wdata(value_q), .raddr(raddr),
		.rdata()
	);

	// Slot valid bits, read registered alongside the key RAM.
	hsbe_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_valid (
		.clk(clk), .we(vld_we), .waddr(vld_waddr), .wdata(vld_wdata), .raddr(raddr),
		.rdata(valid_rd)
	);

	// Scan sequencer, clearing counter and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(TOTAL - 1)) state_q <= B_IDLE;
				end
				B_IDLE: if (job_valid && !rsp_valid_q) state_q <= B_READ;
				B_READ: state_q <= B_CHECK;
				B_CHECK: if (chk_q == SCNT_W'(SLOTS_PER_BUCKET - 1)) state_q <= B_WRITE;
				B_WRITE: state_q <= B_RESP;
				B_RESP: begin
					rsp_valid_q <= 1'b1;
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Scan datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_CLEAR: ;
			B_IDLE: begin
				kind_q  <= job_kind;
				key_q   <= job_key;
				value_q <= job_value;
				base_q  <= ADDR_W'(job_bucket) * ADDR_W'(SLOTS_PER_BUCKET);
				rd_q    <= '0;
				chk_q   <= '0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end
			B_READ: rd_q <= rd_q + 1'b1;
			B_CHECK: begin
				rd_q  <= rd_q + 1'b1;
				chk_q <= chk_q + 1'b1;
				if (valid_rd) begin
					if (!hit_q && key_rd == key_q) begin
						hit_q      <= 1'b1;
						hit_slot_q <= chk_q[SLOT_W-1:0];
					end
				end else if (!free_q) begin
					free_q      <= 1'b1;
					free_slot_q <= chk_q[SLOT_W-1:0];
				end
			end
			B_WRITE: begin
				rsp_q.success     <= hit_q || (is_insert && free_q);
				rsp_q.bucket_full <= is_insert && !hit_q && !free_q;
			end
			B_RESP: ;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_full_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.payload.bucket_full) |-> !rsp.payload.success)
		else $error("full with success");
	a_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_IDLE) |-> !job_ready) else $error("job taken while busy");
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RESP) |=> rsp.valid) else $error("result lost");
`endif

endmodule
`default_nettype wire

// ===== design/hash_set_bucket_engine.sv =====
`default_nettype none
// Hash table engine with fixed bucket slots. Each request (insert, delete or
// search) yields one result. The front end's restoring divider (key modulo
// bucket count, one bit per cycle) takes no new request until it has handed
// its bucket to the queue. The back end takes a request from the queue once
// its last result has been taken, scans the bucket's slots one per cycle
// through the single read port of the key and valid RAMs and then writes back.
// A two-entry queue between the two lets the divider work on the next request
// while the back end scans. After reset the back end clears the slot valid
// bits in a pass over all MAX_BUCKETS * SLOTS_PER_BUCKET slots; the front end
// and queue accept requests meanwhile, but no result comes earlier.
// Write bucket_count only while the engine is idle.
module hash_set_bucket_engine #(
	parameter int MAX_BUCKETS = 1024,
	parameter int SLOTS_PER_BUCKET = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hsbe_req_if.sink  req,
	hsbe_rsp_if.source rsp,
	hsbe_cfg_if.sink  cfg
);

	localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int Q_W   = 2 + hsbe_pkg::KEY_W + BKT_W + hsbe_pkg::VALUE_W;

	logic [hsbe_pkg::COUNT_W-1:0] count_q;
	logic                         f_valid;
	logic                         f_ready;
	logic [1:0]                   f_kind;
	logic [hsbe_pkg::KEY_W-1:0]   f_key;
	logic [BKT_W-1:0]             f_bucket;
	logic [hsbe_pkg::VALUE_W-1:0] value_q;
	logic                         b_valid;
	logic                         b_ready;
	logic [Q_W-1:0]               b_data;

	assign cfg.ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= hsbe_pkg::COUNT_RESET;
		end else if (cfg.valid) begin
			count_q <= cfg.data;
		end
	end

	// The value rides beside the divider.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) value_q <= req.payload.item_value;
	end

	hsbe_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
		.clk(clk), .arst_n(arst_n), .req(req), .bucket_count(count_q),
		.job_valid(f_valid), .job_ready(f_ready), .job_kind(f_kind),
		.job_key(f_key), .job_bucket(f_bucket)
	);

	hsbe_queue #(.WIDTH(Q_W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready),
		.in_data({f_kind, f_key, f_bucket, value_q}),
		.out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
	);

	hsbe_back #(.MAX_BUCKETS(MAX_BUCKETS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(b_valid), .job_ready(b_ready),
		.job_kind(b_data[Q_W-1 -: 2]),
		.job_key(b_data[Q_W-3 -: hsbe_pkg::KEY_W]),
		.job_bucket(b_data[hsbe_pkg::VALUE_W +: BKT_W]),
		.job_value(b_data[hsbe_pkg::VALUE_W-1:0]),
		.rsp(rsp)
	);

`ifndef SYNTHESIS
	a_count_reset: assert property (@(posedge clk)
		!arst_n |=> (count_q == hsbe_pkg::COUNT_RESET) || !arst_n)
		else $error("count reset");
	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |=> (count_q == $past(cfg.data))) else $error("config write lost");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
`endif

endmodule
`default_nettype wire

// ===== bench/hash_set_bucket_engine_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module hash_set_bucket_engine_tb;

	localparam int NBKT  = 1024;
	localparam int NSLOT = 8;
	localparam int NRAND = 530;
	localparam int HOLD_LEN = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hsbe_req_if req ();
	hsbe_rsp_if rsp ();
	hsbe_cfg_if cfg ();

	hash_set_bucket_engine #(.MAX_BUCKETS(NBKT), .SLOTS_PER_BUCKET(NSLOT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	always #2 clk = ~clk;

	// Predictor state: mirror of the slot table and the bucket count.
	logic [hsbe_pkg::KEY_W-1:0]   tbl_key [NBKT*NSLOT];
	logic [hsbe_pkg::VALUE_W-1:0] tbl_val [NBKT*NSLOT];
	logic                         tbl_used [NBKT*NSLOT];
	logic [hsbe_pkg::COUNT_W-1:0] bucket_reg;
	logic [hsbe_pkg::COUNT_W-1:0] counts [6] =
		'{11'd0, 11'd2047, 11'd1, 11'd7, 11'd1025, 11'd3};

	hsbe_pkg::rsp_t pending_rsp [$];
	int   errors = 0;
	int   n_sent = 0;
	int   n_recv = 0;
	int   n_full = 0;
	int   n_hit = 0;
	bit   hold_rsp = 1'b0;
	bit   stim_done = 1'b0;

	// Effective bucket count with the zero and oversize clamps.
	function automatic int live_buckets();
		int n;
		n = int'(bucket_reg);
		if (n == 0) begin
			n = 1;
		end
		if (n > NBKT) begin
			n = NBKT;
		end
		return n;
	endfunction

	// Apply one request to the table mirror and return its expected result.
	function automatic hsbe_pkg::rsp_t table_apply(hsbe_pkg::req_t r);
		hsbe_pkg::rsp_t o;
		int base;
		int hit;
		int freeslot;
		base = int'(r.item_key % live_buckets()) * NSLOT;
		hit = -1;
		freeslot = -1;
		o = '0;
		for (int s = 0; s < NSLOT; s++) begin
			if (tbl_used[base+s]) begin
				if (hit < 0 && tbl_key[base+s] == r.item_key) begin
					hit = s;
				end
			end else if (freeslot < 0) begin
				freeslot = s;
			end
		end
		case (hsbe_pkg::kind_t'(r.kind))
			hsbe_pkg::KIND_INSERT: begin
				if (hit >= 0) begin
					o.success = 1'b1;
				end else if (freeslot >= 0) begin
					tbl_key[base+freeslot] = r.item_key;
					tbl_val[base+freeslot] = r.item_value;
					tbl_used[base+freeslot] = 1'b1;
					o.success = 1'b1;
				end else begin
					o.bucket_full = 1'b1;
				end
			end
			hsbe_pkg::KIND_DELETE: begin
				if (hit >= 0) begin
					tbl_used[base+hit] = 1'b0;
					o.success = 1'b1;
				end
			end
			default: begin
				o.success = (hit >= 0);
			end
		endcase
		return o;
	endfunction

	// Gap length: mostly short, sometimes long, often none.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(20, 150);
	endfunction

	task automatic idle_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	// Drive one request and wait until it is accepted; predict at acceptance.
	// Returns at the falling edge after acceptance with valid still raised.
	task automatic send_request(hsbe_pkg::req_t r, bit check_fixed,
			hsbe_pkg::rsp_t fixed);
		hsbe_pkg::rsp_t p;
		req.valid <= 1'b1;
		req.payload <= r;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		p = table_apply(r);
		if (check_fixed && p != fixed) begin
			$error("directed row mismatch: predictor %b, table %b", p, fixed);
			errors++;
		end
		pending_rsp.push_back(p);
		n_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait, unless the next request follows at once.
	task automatic req_gap(int n);
		if (n > 0) begin
			req.valid <= 1'b0;
			idle_cycles(n);
		end
	endtask

	task automatic write_bucket_count(logic [hsbe_pkg::COUNT_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) begin
			@(posedge clk);
		end
		bucket_reg = v;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Wait until the engine has returned every expected result, then settle.
	task automatic drain();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) begin
			@(negedge clk);
		end
		idle_cycles(100);
	endtask

	function automatic hsbe_pkg::req_t make_req(hsbe_pkg::kind_t k,
			logic [hsbe_pkg::KEY_W-1:0] key, logic [hsbe_pkg::VALUE_W-1:0] v);
		hsbe_pkg::req_t r;
		r.kind = k;
		r.item_key = key;
		r.item_value = v;
		return r;
	endfunction

	// Directed table: expected result typed in where obvious.
	typedef struct {
		hsbe_pkg::kind_t              k;
		logic [hsbe_pkg::KEY_W-1:0]   key;
		logic [hsbe_pkg::VALUE_W-1:0] v;
		bit                           fixed;
		hsbe_pkg::rsp_t               exp_rsp;
	} row_t;

	localparam logic [hsbe_pkg::KEY_W-1:0] KMAX = {hsbe_pkg::KEY_W{1'b1}};

	row_t rows [20] = '{
		'{hsbe_pkg::KIND_SEARCH, 63'd5, 64'd0, 1'b1, 2'b00},
		'{hsbe_pkg::KIND_DELETE, 63'd5, 64'd0, 1'b1, 2'b00},
		'{hsbe_pkg::KIND_INSERT, 63'd0, {1'b1, 63'd0}, 1'b1, 2'b10},
		'{hsbe_pkg::KIND_INSERT, KMAX, {64{1'b1}}, 1'b1, 2'b10},
		'{hsbe_pkg::KIND_SEARCH, KMAX, 64'd0, 1'b0, 2'b00},
		'{hsbe_pkg::KIND_INSERT, KMAX, 64'h7fff_ffff_ffff_ffff, 1'b1, 2'b10},
		'{hsbe_pkg::KIND_SPARE, 63'd0, 64'd0, 1'b0, 2'b00},
		'{hsbe_pkg::KIND_DELETE, KMAX, 64'd0, 1'b0, 2'b00},
		'{hsbe_pkg::KIND_SEARCH, KMAX, 64'd0, 1'b1, 2'b00},
		'{hsbe_pkg::KIND_INSERT, 63'd1024, 64'd1, 1'b0, 2'b00},
		'{hsbe_pkg::KIND_INSERT, 63'd2048, 64'd2, 1'b0, 2'b00},
		'{hsbe_pkg::KIND_INSERT, 63'd3072, 64'd3, 1'b0, 2'b00},
		'{hsbe_pkg::KIND_INSERT, 63'd4096, 64'd4, 1'b0, 2'b00},
		'{hsbe_pkg::KIND_INSERT, 63'd5120, 64'd5, 1'b0, 2'b00},
		'{hsbe_pkg::KIND_INSERT, 63'd6144, 64'd6, 1'b0, 2'b00},
		'{hsbe_pkg::KIND_INSERT, 63'd7168, 64'd7, 1'b0, 2'b00},
		'{hsbe_pkg::KIND_INSERT, 63'd8192, 64'd8, 1'b1, 2'b01},
		'{hsbe_pkg::KIND_SEARCH, 63'd8192, 64'd0, 1'b1, 2'b00},
		'{hsbe_pkg::KIND_DELETE, 63'd0, 64'd0, 1'b0, 2'b00},
		'{hsbe_pkg::KIND_INSERT, 63'd8192, 64'd9, 1'b0, 2'b00}
	};

	// Random request: keys drawn from a small pool so hits and full buckets occur.
	function automatic hsbe_pkg::req_t random_req(int pool);
		hsbe_pkg::req_t r;
		int p;
		r.kind = $urandom_range(0, 99) < 45 ? hsbe_pkg::KIND_INSERT :
			2'($urandom_range(1, 3));
		p = $urandom_range(0, 9);
		if (p == 0) begin
			r.item_key = 63'({$urandom, $urandom});
		end else if (p == 1) begin
			r.item_key = KMAX - 63'($urandom_range(0, 40));
		end else begin
			r.item_key = 63'($urandom_range(0, pool));
		end
		r.item_value = {$urandom, $urandom};
		return r;
	endfunction

	// Stimulus.
	initial begin
		hsbe_pkg::req_t r;
		req.valid = 1'b0;
		req.payload = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		bucket_reg = hsbe_pkg::COUNT_RESET;
		for (int i = 0; i < NBKT*NSLOT; i++) begin
			tbl_used[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_val[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_cycles(2);

		foreach (rows[i]) begin
			send_request(make_req(rows[i].k, rows[i].key, rows[i].v), rows[i].fixed,
				rows[i].exp_rsp);
			req_gap(pick_gap());
		end
		drain();

		// Random phases, each after writing a different bucket count setting.
		for (int ph = 0; ph < 6; ph++) begin
			write_bucket_count(counts[ph]);
			for (int i = 0; i < NRAND / 6; i++) begin
				r = random_req(ph < 3 ? 40 : 4000);
				send_request(r, 1'b0, '0);
				// Long receiver hold-off while requests keep coming.
				if (ph == 1 && i == 10) begin
					hold_rsp = 1'b1;
				end
				if (ph == 2 && i == 40) begin
					// Sender waits for every result once mid-phase.
					req.valid <= 1'b0;
					while (pending_rsp.size() != 0) begin
						@(negedge clk);
					end
					idle_cycles(1);
				end else if (!(ph == 1 && i >= 10 && i < 16)) begin
					req_gap(pick_gap());
				end
			end
			drain();
		end
		write_bucket_count(hsbe_pkg::COUNT_RESET);
		stim_done = 1'b1;
	end

	// Result side: ready with random stalls, check against oldest expectation.
	initial begin
		hsbe_pkg::rsp_t e;
		int gap;
		int hold_cycles;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
				hold_cycles = 0;
				while (hold_cycles < HOLD_LEN) begin
					@(negedge clk);
					hold_cycles++;
				end
				hold_rsp = 1'b0;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					rsp.ready <= 1'b0;
					idle_cycles(gap);
				end
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) begin
				@(posedge clk);
			end
			n_recv++;
			if (pending_rsp.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.payload.success !== e.success) begin
					$error("success: expected %b actual %b", e.success,
						rsp.payload.success);
					errors++;
				end
				if (rsp.payload.bucket_full !== e.bucket_full) begin
					$error("bucket_full: expected %b actual %b", e.bucket_full,
						rsp.payload.bucket_full);
					errors++;
				end
				if (e.bucket_full) begin
					n_full++;
				end
				if (e.success) begin
					n_hit++;
				end
			end
		end
	end

	// End of run.
	initial begin
		wait (stim_done);
		idle_cycles(200);
		if (pending_rsp.size() != 0) begin
			$error("%0d results never arrived", pending_rsp.size());
			errors++;
		end
		$display("Sent %0d requests over seven bucket count settings; %0d results came back.",
			n_sent, n_recv);
		$display("Of these, %0d succeeded and %0d hit a full bucket.", n_hit, n_full);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#8ms;
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

// ===== hash_set_bucket_engine.f =====
design/hsbe_pkg.sv
design/hsbe_req_if.sv
design/hsbe_rsp_if.sv
design/hsbe_cfg_if.sv
design/hsbe_ram.sv
design/hsbe_front.sv
design/hsbe_queue.sv
design/hsbe_back.sv
design/hash_set_bucket_engine.sv
bench/hash_set_bucket_engine_tb.sv
